// ----- design/euler_rotation_matrix_macros.svh -----
// Assertion macros for the Euler rotation matrix block
`ifndef EULER_ROTATION_MATRIX_MACROS_SVH
`define EULER_ROTATION_MATRIX_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ERM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("erm assertion failed");
// expression must never be true outside reset
`define ERM_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("erm forbidden condition seen");
`else
`define ERM_ASSERT(lbl, clk, rst, prop)
`define ERM_ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ----- design/erm_pkg.sv -----
// Shared types, constants and term tables for the Euler rotation matrix block
`default_nettype none
package erm_pkg;

   localparam int CORDIC_ITER_DEF = 14;
   localparam int ATAN_ENTRIES    = 24;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int NUM_LANES       = 3;

   localparam int ANGLE_W = 16;
   localparam int BAM_W   = 32;
   localparam int CW      = 33;   // CORDIC x/y/z width
   localparam int TRIG_W  = 23;   // sin/cos in Q.20
   localparam int AB_W    = 2 * TRIG_W;
   localparam int PROD_W  = 64;
   localparam int ELEM_W  = 16;
   localparam int IDX_W   = 4;
   localparam int CONV_W  = 2;
   localparam int RES_SHIFT = 46;
   localparam int RES_W   = PROD_W - RES_SHIFT;
   localparam int KSPLIT  = 17;
   localparam int LO_W    = 22;   // low slice of a*b for the second multiply

   // radians (Q4.12) to binary angle, split for two narrow multiplies
   localparam logic [33:0] RAD_TO_BAM = 34'd10937044422;
   localparam logic signed [KSPLIT:0] K_LO = {1'b0, KSPLIT'(RAD_TO_BAM % (2 ** KSPLIT))};
   localparam logic signed [KSPLIT:0] K_HI = {1'b0, KSPLIT'(RAD_TO_BAM >> KSPLIT)};

   localparam logic signed [CW-1:0]     CORDIC_GAIN = 33'sd652032874;
   localparam logic signed [TRIG_W-1:0] ONE_Q20     = 23'sd1048576;
   localparam logic signed [PROD_W-1:0] ROUND_BIAS  = 64'sh0000_2000_0000_0000;
   localparam logic signed [RES_W-1:0]  ELEM_MAX    = 18'sd16384;
   localparam logic [IDX_W-1:0]         LAST_IDX    = 4'd8;

   localparam logic [BAM_W-1:0] ATAN_BAM [ATAN_ENTRIES] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef enum logic [CONV_W-1:0] {
      CONV_RPY0 = 2'd0,
      CONV_RPY1 = 2'd1,
      CONV_POK  = 2'd2
   } conv_type;

   typedef enum logic [2:0] {
      F_ZERO, F_ONE, F_SA, F_CA, F_SB, F_CB, F_SC, F_CC
   } factor_type;

   typedef struct packed {
      factor_type f0;
      factor_type f1;
      factor_type f2;
      logic       neg;
   } term_type;

   typedef struct packed {
      term_type t1;
      term_type t2;
   } elem_terms_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] sa;
      logic signed [TRIG_W-1:0] ca;
      logic signed [TRIG_W-1:0] sb;
      logic signed [TRIG_W-1:0] cb;
      logic signed [TRIG_W-1:0] sc;
      logic signed [TRIG_W-1:0] cc;
   } trig_type;

   function automatic term_type mk(input factor_type f0, input factor_type f1,
                                   input factor_type f2, input logic neg);
      term_type t;
      t.f0 = f0; t.f1 = f1; t.f2 = f2; t.neg = neg;
      return t;
   endfunction

   localparam term_type NO_TERM = '{f0: F_ZERO, f1: F_ZERO, f2: F_ZERO, neg: 1'b0};

   // up to two signed three-factor terms per element; shorter terms use ONE, unused ones ZERO
   function automatic elem_terms_type elem_terms(input logic rpy, input logic [IDX_W-1:0] idx);
      elem_terms_type e;
      e.t1 = NO_TERM;
      e.t2 = NO_TERM;
      if (rpy) begin
         unique case (idx)
            4'd0: e.t1 = mk(F_CA, F_CC, F_ONE, 1'b0);
            4'd1: e.t1 = mk(F_CA, F_SC, F_ONE, 1'b1);
            4'd2: e.t1 = mk(F_SA, F_ONE, F_ONE, 1'b1);
            4'd3: begin e.t1 = mk(F_CB, F_SC, F_ONE, 1'b0); e.t2 = mk(F_SA, F_SB, F_CC, 1'b0); end
            4'd4: begin e.t1 = mk(F_CB, F_CC, F_ONE, 1'b0); e.t2 = mk(F_SA, F_SB, F_SC, 1'b1); end
            4'd5: e.t1 = mk(F_CA, F_SB, F_ONE, 1'b0);
            4'd6: begin e.t1 = mk(F_SA, F_CC, F_CB, 1'b0); e.t2 = mk(F_SB, F_SC, F_ONE, 1'b1); end
            4'd7: begin e.t1 = mk(F_CB, F_SA, F_SC, 1'b1); e.t2 = mk(F_SB, F_CC, F_ONE, 1'b1); end
            4'd8: e.t1 = mk(F_CA, F_CB, F_ONE, 1'b0);
            default: e.t1 = NO_TERM;
         endcase
      end else begin
         unique case (idx)
            4'd0: begin e.t1 = mk(F_CA, F_CC, F_ONE, 1'b0); e.t2 = mk(F_SA, F_SB, F_SC, 1'b1); end
            4'd1: begin e.t1 = mk(F_CA, F_SC, F_ONE, 1'b1); e.t2 = mk(F_SA, F_SB, F_CC, 1'b1); end
            4'd2: e.t1 = mk(F_SA, F_CB, F_ONE, 1'b1);
            4'd3: e.t1 = mk(F_CB, F_SC, F_ONE, 1'b0);
            4'd4: e.t1 = mk(F_CB, F_CC, F_ONE, 1'b0);
            4'd5: e.t1 = mk(F_SB, F_ONE, F_ONE, 1'b1);
            4'd6: begin e.t1 = mk(F_SA, F_CC, F_ONE, 1'b0); e.t2 = mk(F_CA, F_SB, F_SC, 1'b0); end
            4'd7: begin e.t1 = mk(F_SA, F_SC, F_ONE, 1'b1); e.t2 = mk(F_CA, F_SB, F_CC, 1'b0); end
            4'd8: e.t1 = mk(F_CA, F_CB, F_ONE, 1'b0);
            default: e.t1 = NO_TERM;
         endcase
      end
      return e;
   endfunction

endpackage
`default_nettype wire

// ----- design/erm_front.sv -----
// Front end: angle to binary angle, quadrant fold and pipelined CORDIC per angle
`default_nettype none
module erm_front #(
   parameter int CORDIC_ITERATIONS = erm_pkg::CORDIC_ITER_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [erm_pkg::ANGLE_W-1:0] req_angle_a,
   input  wire logic signed [erm_pkg::ANGLE_W-1:0] req_angle_b,
   input  wire logic signed [erm_pkg::ANGLE_W-1:0] req_angle_c,
   output logic                                   trig_valid,
   input  wire logic                              trig_ready,
   output erm_pkg::trig_type                      trig_data
);
   localparam int CW  = erm_pkg::CW;
   localparam int NL  = erm_pkg::NUM_LANES;
   localparam int PPW = erm_pkg::ANGLE_W + erm_pkg::KSPLIT + 1;
   localparam int TW  = erm_pkg::TRIG_W;

   logic fe;
   logic signed [erm_pkg::ANGLE_W-1:0] ang [NL];

   // whole front pipeline moves together unless the final stage is blocked
   assign fe        = !trig_valid || trig_ready;
   assign req_ready = fe;
   assign ang[0] = req_angle_a;
   assign ang[1] = req_angle_b;
   assign ang[2] = req_angle_c;

   // partial products of angle times radians-to-binary-angle constant
   logic                  m_valid_ff;
   logic signed [PPW-1:0] ppl_ff [NL];
   logic signed [PPW-1:0] pph_ff [NL];

   always_ff @(posedge clock) begin
      if (reset) m_valid_ff <= 1'b0;
      else if (fe) m_valid_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (fe) begin
         for (int l = 0; l < NL; l++) begin
            ppl_ff[l] <= ang[l] * erm_pkg::K_LO;
            pph_ff[l] <= ang[l] * erm_pkg::K_HI;
         end
      end
   end

   // CORDIC stage registers, stage 0 is the folded start point
   logic                vld_ff [CORDIC_ITERATIONS+1];
   logic signed [CW-1:0] x_ff  [CORDIC_ITERATIONS+1][NL];
   logic signed [CW-1:0] y_ff  [CORDIC_ITERATIONS+1][NL];
   logic signed [CW-1:0] z_ff  [CORDIC_ITERATIONS+1][NL];
   logic                neg_ff [CORDIC_ITERATIONS+1][NL];

   // binary angle and fold of quadrants 1 and 2 onto the right half plane
   always_ff @(posedge clock) begin
      logic signed [47:0] prod;
      logic [erm_pkg::BAM_W-1:0] bam;
      logic neg;
      if (fe) begin
         for (int l = 0; l < NL; l++) begin
            prod = (48'(pph_ff[l]) <<< erm_pkg::KSPLIT) + 48'(ppl_ff[l]);
            bam  = prod[47:16];
            neg  = (bam[31:30] == 2'b01) || (bam[31:30] == 2'b10);
            if (neg) bam = bam + 32'h8000_0000;
            x_ff[0][l]   <= erm_pkg::CORDIC_GAIN;
            y_ff[0][l]   <= '0;
            z_ff[0][l]   <= CW'(signed'(bam));
            neg_ff[0][l] <= neg;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff[0] <= 1'b0;
      else if (fe) vld_ff[0] <= m_valid_ff;
   end

   // one micro-rotation per stage
   for (genvar k = 0; k < CORDIC_ITERATIONS; k++) begin : g_stage
      localparam logic signed [CW-1:0] ATAN_K = {1'b0, erm_pkg::ATAN_BAM[k]};

      always_ff @(posedge clock) begin
         if (reset) vld_ff[k+1] <= 1'b0;
         else if (fe) vld_ff[k+1] <= vld_ff[k];
      end

      always_ff @(posedge clock) begin
         if (fe) begin
            for (int l = 0; l < NL; l++) begin
               if (z_ff[k][l] >= 0) begin
                  x_ff[k+1][l] <= x_ff[k][l] - (y_ff[k][l] >>> k);
                  y_ff[k+1][l] <= y_ff[k][l] + (x_ff[k][l] >>> k);
                  z_ff[k+1][l] <= z_ff[k][l] - ATAN_K;
               end else begin
                  x_ff[k+1][l] <= x_ff[k][l] + (y_ff[k][l] >>> k);
                  y_ff[k+1][l] <= y_ff[k][l] - (x_ff[k][l] >>> k);
                  z_ff[k+1][l] <= z_ff[k][l] + ATAN_K;
               end
               neg_ff[k+1][l] <= neg_ff[k][l];
            end
         end
      end
   end

   // round Q.30 to Q.20 and undo the fold
   logic                  rnd_valid_ff;
   logic signed [TW-1:0]  sin_ff [NL];
   logic signed [TW-1:0]  cos_ff [NL];

   always_ff @(posedge clock) begin
      if (reset) rnd_valid_ff <= 1'b0;
      else if (fe) rnd_valid_ff <= vld_ff[CORDIC_ITERATIONS];
   end

   always_ff @(posedge clock) begin
      logic signed [CW-1:0] xr;
      logic signed [CW-1:0] yr;
      if (fe) begin
         for (int l = 0; l < NL; l++) begin
            xr = (x_ff[CORDIC_ITERATIONS][l] + CW'(512)) >>> 10;
            yr = (y_ff[CORDIC_ITERATIONS][l] + CW'(512)) >>> 10;
            if (neg_ff[CORDIC_ITERATIONS][l]) begin
               xr = -xr;
               yr = -yr;
            end
            cos_ff[l] <= xr[TW-1:0];
            sin_ff[l] <= yr[TW-1:0];
         end
      end
   end

   assign trig_valid   = rnd_valid_ff;
   assign trig_data.sa = sin_ff[0];
   assign trig_data.ca = cos_ff[0];
   assign trig_data.sb = sin_ff[1];
   assign trig_data.cb = cos_ff[1];
   assign trig_data.sc = sin_ff[2];
   assign trig_data.cc = cos_ff[2];

endmodule
`default_nettype wire

// ----- design/erm_queue.sv -----
// Short queue of sine/cosine sets between front and back end
`default_nettype none
module erm_queue #(
   parameter int QUEUE_DEPTH = erm_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire erm_pkg::trig_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output erm_pkg::trig_type      out_data
);
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   erm_pkg::trig_type mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic push, pop;

   assign in_ready  = cnt_ff != CNT_FULL;
   assign out_valid = cnt_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = mem_ff[rd_ptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         if (push && !pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= in_data;
   end

endmodule
`default_nettype wire

// ----- design/erm_back.sv -----
// Back end: issues nine elements per set and forms them in a multiply pipeline
`default_nettype none
`include "euler_rotation_matrix_macros.svh"
module erm_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [erm_pkg::CONV_W-1:0]       convention,
   input  wire logic                             q_valid,
   output logic                                  q_ready,
   input  wire erm_pkg::trig_type                q_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [erm_pkg::IDX_W-1:0]             rsp_element_index,
   output logic signed [erm_pkg::ELEM_W-1:0]     rsp_element_value,
   output logic                                  rsp_last_element
);
   localparam int TW = erm_pkg::TRIG_W;
   localparam int AW = erm_pkg::AB_W;
   localparam int PW = erm_pkg::PROD_W;
   localparam int LW = erm_pkg::LO_W;
   localparam int IW = erm_pkg::IDX_W;

   logic adv, load;
   logic rpy, swap;
   erm_pkg::trig_type cur_ff, tsel;
   logic cur_valid_ff;
   logic [IW-1:0] cnt_ff;
   erm_pkg::elem_terms_type et;

   function automatic logic signed [TW-1:0] fval(input erm_pkg::factor_type f,
                                                input erm_pkg::trig_type t);
      logic signed [TW-1:0] v;
      unique case (f)
         erm_pkg::F_ONE: v = erm_pkg::ONE_Q20;
         erm_pkg::F_SA:  v = t.sa;
         erm_pkg::F_CA:  v = t.ca;
         erm_pkg::F_SB:  v = t.sb;
         erm_pkg::F_CB:  v = t.cb;
         erm_pkg::F_SC:  v = t.sc;
         erm_pkg::F_CC:  v = t.cc;
         default:        v = '0;
      endcase
      return v;
   endfunction

   // whole back pipeline stalls only when the output register is held
   assign adv  = !rsp_valid || rsp_ready;
   assign load = q_valid && (!cur_valid_ff || (adv && cnt_ff == erm_pkg::LAST_IDX));
   assign q_ready = load;

   // current set and element counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else if (load) begin
         cur_valid_ff <= 1'b1;
         cnt_ff       <= '0;
      end else if (adv && cur_valid_ff) begin
         if (cnt_ff == erm_pkg::LAST_IDX) cur_valid_ff <= 1'b0;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) cur_ff <= q_data;
   end

   // convention decode; second rpy order swaps the first two angles
   assign rpy  = (convention == erm_pkg::CONV_RPY0) || (convention == erm_pkg::CONV_RPY1);
   assign swap = convention == erm_pkg::CONV_RPY1;
   assign et   = erm_pkg::elem_terms(rpy, cnt_ff);

   always_comb begin
      tsel = cur_ff;
      if (swap) begin
         tsel.sa = cur_ff.sb;
         tsel.sb = cur_ff.sa;
         tsel.ca = cur_ff.cb;
         tsel.cb = cur_ff.ca;
      end
   end

   // pipeline valid chain: issue, a*b, partials, terms, sum, output
   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0; v1_ff <= 1'b0; v2_ff <= 1'b0;
         v3_ff <= 1'b0; v4_ff <= 1'b0; rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= cur_valid_ff;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         rsp_valid_ff <= v4_ff;
      end
   end
   assign rsp_valid = rsp_valid_ff;

   logic signed [TW-1:0] a1_ff, b1_ff, c1_ff, a2_ff, b2_ff, c2_ff, c1s1_ff, c2s1_ff;
   logic n1_ff [5], n2_ff [5];
   logic [IW-1:0] idx_ff [5];
   logic signed [AW-1:0] ab1_ff, ab2_ff;
   logic signed [AW-1:0] plo1_ff, plo2_ff;
   logic signed [AW:0]   phi1_ff, phi2_ff;
   logic signed [PW-1:0] t1_ff, t2_ff, e_ff;
   logic [IW-1:0] rsp_element_index_ff;
   logic signed [erm_pkg::ELEM_W-1:0] rsp_element_value_ff;
   logic rsp_last_element_ff;

   always_ff @(posedge clock) begin
      logic signed [PW-1:0] t1, t2;
      logic signed [erm_pkg::RES_W-1:0] r;
      if (adv) begin
         // issue: pick factors for this element
         a1_ff <= fval(et.t1.f0, tsel);
         b1_ff <= fval(et.t1.f1, tsel);
         c1_ff <= fval(et.t1.f2, tsel);
         a2_ff <= fval(et.t2.f0, tsel);
         b2_ff <= fval(et.t2.f1, tsel);
         c2_ff <= fval(et.t2.f2, tsel);
         n1_ff[0]  <= et.t1.neg;
         n2_ff[0]  <= et.t2.neg;
         idx_ff[0] <= cnt_ff;
         // first product
         ab1_ff  <= a1_ff * b1_ff;
         ab2_ff  <= a2_ff * b2_ff;
         c1s1_ff <= c1_ff;
         c2s1_ff <= c2_ff;
         // third factor in two slices of a*b, upper slice keeps the sign
         plo1_ff <= signed'({1'b0, ab1_ff[LW-1:0]}) * c1s1_ff;
         phi1_ff <= signed'(ab1_ff[AW-1:LW]) * c1s1_ff;
         plo2_ff <= signed'({1'b0, ab2_ff[LW-1:0]}) * c2s1_ff;
         phi2_ff <= signed'(ab2_ff[AW-1:LW]) * c2s1_ff;
         // rebuild terms and apply signs
         t1 = (PW'(phi1_ff) <<< LW) + PW'(plo1_ff);
         t2 = (PW'(phi2_ff) <<< LW) + PW'(plo2_ff);
         t1_ff <= n1_ff[2] ? -t1 : t1;
         t2_ff <= n2_ff[2] ? -t2 : t2;
         // exact sum plus rounding bias
         e_ff <= t1_ff + t2_ff + erm_pkg::ROUND_BIAS;
         // round to Q.14 and saturate
         r = PW'(e_ff >>> erm_pkg::RES_SHIFT) == e_ff >>> erm_pkg::RES_SHIFT ?
             erm_pkg::RES_W'(e_ff >>> erm_pkg::RES_SHIFT) : '0;
         if (r > erm_pkg::ELEM_MAX)       r = erm_pkg::ELEM_MAX;
         else if (r < -erm_pkg::ELEM_MAX) r = -erm_pkg::ELEM_MAX;
         rsp_element_value_ff <= r[erm_pkg::ELEM_W-1:0];
         rsp_element_index_ff <= idx_ff[4];
         rsp_last_element_ff  <= idx_ff[4] == erm_pkg::LAST_IDX;
         for (int s = 1; s < 5; s++) begin
            n1_ff[s]  <= n1_ff[s-1];
            n2_ff[s]  <= n2_ff[s-1];
            idx_ff[s] <= idx_ff[s-1];
         end
      end
   end

   assign rsp_element_index = rsp_element_index_ff;
   assign rsp_element_value = rsp_element_value_ff;
   assign rsp_last_element  = rsp_last_element_ff;

   `ERM_ASSERT(a_cnt_range, clock, reset, cur_valid_ff |-> cnt_ff <= erm_pkg::LAST_IDX)
   `ERM_ASSERT(a_last_idx, clock, reset, rsp_valid && rsp_last_element |-> rsp_element_index == erm_pkg::LAST_IDX)
   `ERM_ASSERT_NEVER(a_load_empty, clock, reset, q_ready && !q_valid)

endmodule
`default_nettype wire

// ----- design/euler_rotation_matrix.sv -----
// The back end's multiply pipeline forms one element per cycle unless its output is held,
// and each triple has nine. The front end takes one triple per cycle into its CORDIC
// pipeline unless its last stage is blocked; a queue, 4 deep by default, absorbs bursts.
// Reset clears all valid bits and the queue, and sets convention to phi-omega-kappa.
`default_nettype none
module euler_rotation_matrix #(
   parameter int CORDIC_ITERATIONS = erm_pkg::CORDIC_ITER_DEF,
   parameter int QUEUE_DEPTH       = erm_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_en,
   input  wire logic [erm_pkg::CONV_W-1:0]         csr_write_data,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic signed [erm_pkg::ANGLE_W-1:0] req_angle_a,
   input  wire logic signed [erm_pkg::ANGLE_W-1:0] req_angle_b,
   input  wire logic signed [erm_pkg::ANGLE_W-1:0] req_angle_c,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [erm_pkg::IDX_W-1:0]               rsp_element_index,
   output logic signed [erm_pkg::ELEM_W-1:0]       rsp_element_value,
   output logic                                    rsp_last_element
);
   logic [erm_pkg::CONV_W-1:0] convention_ff;
   logic f_valid, f_ready, q_valid, q_ready;
   erm_pkg::trig_type f_data, q_data;

   // convention register
   always_ff @(posedge clock) begin
      if (reset) convention_ff <= erm_pkg::CONV_POK;
      else if (csr_write_en) convention_ff <= csr_write_data;
   end

   erm_front #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_angle_a, .req_angle_b, .req_angle_c,
      .trig_valid(f_valid), .trig_ready(f_ready), .trig_data(f_data)
   );

   erm_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   erm_back u_back (
      .clock, .reset, .convention(convention_ff), .q_valid, .q_ready, .q_data,
      .rsp_valid, .rsp_ready, .rsp_element_index, .rsp_element_value, .rsp_last_element
   );

endmodule
`default_nettype wire
